@@ src/wbps_pkg.sv @@
// ----------------------------------------------------------------------------
// Wildcard byte pattern scan package
// Shared word types, register map codes and port constants for the
// wildcard byte pattern scan core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wbps_pkg;

  // Register port geometry: six registers, the widest is 64 bits, so each
  // register occupies an 8-byte slot.
  localparam int unsigned DATA_W      = 64;
  localparam int unsigned ADDR_W      = 6;
  localparam int unsigned REG_IDX_LSB = 3;
  localparam int unsigned REG_IDX_W   = 3;

  localparam int unsigned LEN_W  = 5;
  localparam int unsigned CARE_W = 16;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PATTERN_LOW    = 3'd0,
    REG_PATTERN_HIGH   = 3'd1,
    REG_CARE_MASK      = 3'd2,
    REG_PATTERN_LENGTH = 3'd3,
    REG_REPORT_ALL     = 3'd4,
    REG_BASE_ADDRESS   = 3'd5
  } reg_idx_e;

  // One streamed byte of the scanned region.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  // One scan result.
  typedef struct packed {
    logic        found;
    logic [63:0] match_address;
    logic        done_res;
  } out_word_t;

endpackage

`default_nettype wire

@@ src/wildcard_byte_pattern_scan_core.sv @@
// ----------------------------------------------------------------------------
// Wildcard byte pattern scan core
// Streams a memory region one byte per word and searches it for a signature
// of up to MAX_PATTERN_BYTES bytes with per-byte wildcards.
// ----------------------------------------------------------------------------
// Pipeline: an input word is registered in stage A, and its result word in the
// output register, once that register is free or being emptied.
// Throughput: one input word per cycle while results are taken; the shift
// window and its parallel byte comparators take a new byte every cycle, and
// the output register lets the next word in while a result waits.
// Reset: rst_ni clears the registers (pattern_length to 1), the window, the
// byte counter and the pipeline valid flags; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module wildcard_byte_pattern_scan_core #(
  parameter int unsigned MAX_PATTERN_BYTES = 16,
  parameter int unsigned COUNT_BITS        = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,

  // Byte stream in.
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire wbps_pkg::in_word_t            in_data_i,

  // Results out.
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      wbps_pkg::out_word_t           out_data_o,

  // Register port.
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [wbps_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [wbps_pkg::DATA_W-1:0]   pwdata,
  output      logic [wbps_pkg::DATA_W-1:0]   prdata,
  output      logic                          pready
);

  localparam int unsigned IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
  localparam int unsigned LEN_W = wbps_pkg::LEN_W;

  // --------------------------------------------------------------------------
  // Configuration registers. Writes complete in the APB access phase; the
  // port never inserts wait states.
  // --------------------------------------------------------------------------
  logic [63:0]                     pattern_low_q;
  logic [63:0]                     pattern_high_q;
  logic [wbps_pkg::CARE_W-1:0]     care_mask_q;
  logic [LEN_W-1:0]                pattern_length_q;
  logic                            report_all_q;
  logic [63:0]                     base_address_q;

  wbps_pkg::reg_idx_e reg_idx;
  logic               cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = wbps_pkg::reg_idx_e'(paddr[wbps_pkg::ADDR_W-1:wbps_pkg::REG_IDX_LSB]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_low_q    <= '0;
      pattern_high_q   <= '0;
      care_mask_q      <= '0;
      pattern_length_q <= LEN_W'(1);
      report_all_q     <= 1'b0;
      base_address_q   <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        wbps_pkg::REG_PATTERN_LOW:    pattern_low_q    <= pwdata;
        wbps_pkg::REG_PATTERN_HIGH:   pattern_high_q   <= pwdata;
        wbps_pkg::REG_CARE_MASK:      care_mask_q      <= pwdata[wbps_pkg::CARE_W-1:0];
        wbps_pkg::REG_PATTERN_LENGTH: pattern_length_q <= pwdata[LEN_W-1:0];
        wbps_pkg::REG_REPORT_ALL:     report_all_q     <= pwdata[0];
        wbps_pkg::REG_BASE_ADDRESS:   base_address_q   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      wbps_pkg::REG_PATTERN_LOW:    prdata = pattern_low_q;
      wbps_pkg::REG_PATTERN_HIGH:   prdata = pattern_high_q;
      wbps_pkg::REG_CARE_MASK:      prdata = {{(64-wbps_pkg::CARE_W){1'b0}}, care_mask_q};
      wbps_pkg::REG_PATTERN_LENGTH: prdata = {{(64-LEN_W){1'b0}}, pattern_length_q};
      wbps_pkg::REG_REPORT_ALL:     prdata = {63'd0, report_all_q};
      wbps_pkg::REG_BASE_ADDRESS:   prdata = base_address_q;
      default:                      prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Effective pattern length. A length of zero behaves as one, and a length
  // beyond the window depth is clamped to the window depth.
  // --------------------------------------------------------------------------
  logic [LEN_W-1:0] len_act;
  logic [LEN_W-1:0] len_m1;

  always_comb begin
    if (pattern_length_q == '0) begin
      len_act = LEN_W'(1);
    end else if (pattern_length_q > LEN_W'(MAX_PATTERN_BYTES)) begin
      len_act = LEN_W'(MAX_PATTERN_BYTES);
    end else begin
      len_act = pattern_length_q;
    end
  end

  assign len_m1 = len_act - LEN_W'(1);

  // --------------------------------------------------------------------------
  // Handshake control. Stage A holds the word that was just shifted into the
  // window; the output register holds a finished result. Stage A may move on
  // whenever the output register is empty or is being emptied.
  // --------------------------------------------------------------------------
  logic a_valid_q;
  logic out_valid_q;
  logic b_ready;
  logic in_fire;
  logic b_fire;

  assign b_ready    = !out_valid_q || out_ready_i;
  assign in_ready_o = !a_valid_q || b_ready;
  assign in_fire    = in_valid_i && in_ready_o;
  assign b_fire     = a_valid_q && b_ready;

  // --------------------------------------------------------------------------
  // Stage A: shift window and saturating byte counter. The counter value
  // after this byte is count_q + 1 unless it has saturated or the byte is
  // final, so the start offset and the "enough bytes seen" test are formed
  // straight from the old count, with one subtract and one compare.
  // --------------------------------------------------------------------------
  logic [7:0]            window_q [MAX_PATTERN_BYTES];
  logic [COUNT_BITS-1:0] count_q;
  logic                  count_sat;
  logic [COUNT_BITS-1:0] len_ext;
  logic [COUNT_BITS-1:0] len_m1_ext;
  logic [COUNT_BITS-1:0] offset_d;
  logic                  enough_d;

  logic [COUNT_BITS-1:0] a_offset_q;
  logic                  a_enough_q;
  logic                  a_last_q;

  assign count_sat  = &count_q;
  assign len_ext    = {{(COUNT_BITS-LEN_W){1'b0}}, len_act};
  assign len_m1_ext = {{(COUNT_BITS-LEN_W){1'b0}}, len_m1};

  always_comb begin
    if (count_sat) begin
      offset_d = count_q - len_ext;
      enough_d = (count_q >= len_ext);
    end else begin
      offset_d = count_q - len_m1_ext;
      enough_d = (count_q >= len_m1_ext);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
        window_q[k] <= '0;
      end
      count_q <= '0;
    end else if (in_fire) begin
      window_q[0] <= in_data_i.data_byte;
      for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
        window_q[k] <= window_q[k-1];
      end
      // A new region starts after the final byte.
      if (in_data_i.last_byte) begin
        count_q <= '0;
      end else if (!count_sat) begin
        count_q <= count_q + COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_fire) begin
      a_valid_q <= 1'b1;
    end else if (b_fire) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_offset_q <= offset_d;
      a_enough_q <= enough_d;
      a_last_q   <= in_data_i.last_byte;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: parallel compare of the newest len_act window bytes against the
  // signature. Signature byte i lines up with the byte received
  // len_act - 1 - i words ago; a clear care bit makes that byte a wildcard.
  // --------------------------------------------------------------------------
  logic [127:0]                   signature;
  logic [MAX_PATTERN_BYTES-1:0]   byte_ok;
  logic                           window_match;
  logic                           hit;

  assign signature = {pattern_high_q, pattern_low_q};

  always_comb begin
    logic [IDX_W-1:0] idx;
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      idx        = IDX_W'(len_m1 - LEN_W'(i));
      byte_ok[i] = (LEN_W'(i) > len_m1) || !care_mask_q[i] ||
                   (window_q[idx] == signature[8*i +: 8]);
    end
  end

  assign window_match = &byte_ok;
  assign hit          = a_enough_q && window_match;

  // In first-match mode only the first hit of a region is reported; a final
  // byte with no hit reports not-found unless first-match mode already hit.
  logic                first_found_q;
  logic                emit;
  wbps_pkg::out_word_t res_d;
  wbps_pkg::out_word_t out_data_q;

  assign emit = (report_all_q || !first_found_q) && (hit || a_last_q);

  always_comb begin
    res_d.found         = hit;
    res_d.match_address = hit ? (base_address_q + {{(64-COUNT_BITS){1'b0}}, a_offset_q})
                              : 64'd0;
    res_d.done_res      = report_all_q ? a_last_q : 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_found_q <= 1'b0;
    end else if (b_fire) begin
      if (a_last_q) begin
        first_found_q <= 1'b0;
      end else if (!report_all_q && hit) begin
        first_found_q <= 1'b1;
      end
    end
  end

  // Output register: loaded by a reporting word, emptied when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (b_fire && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_fire && emit) begin
      out_data_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.found) |-> (out_data_o.match_address == 64'd0 &&
                                            out_data_o.done_res))
    else $error("not-found word must carry a zero address and done");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_fire && emit && !report_all_q) |=> (out_valid_o && out_data_o.done_res))
    else $error("first-match mode result must end the scan");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (a_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a full pipeline");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.last_byte) |=> (count_q == '0))
    else $error("byte counter not cleared after the final byte");

endmodule

`default_nettype wire
